>>> rtl/sms_pkg.sv
// shared types and constants for the similarity mask scoring block
// item and result payloads, queue command, configuration codes
// no dependencies
package sms_pkg;

    localparam int MAX_CONTROLS_DEF    = 64;
    localparam int MASK_ROWS_DEF       = 64;
    localparam int MASK_COLS_DEF       = 64;
    localparam int COORD_FRAC_BITS_DEF = 8;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = 25;
    localparam int PROD_W  = 50;
    localparam int SUM_W   = 51;
    localparam int NUM_W   = 50;
    localparam int AB_FRAC = 16;
    localparam int AB_MAG_W = 36;
    localparam int AB_W    = 37;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 4;
    localparam int HIT_W   = 7;
    localparam int WORD_W  = 64;
    localparam int IDX_W   = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_CONTROLS = 4'd0,
        CFG_MASK_ROWS    = 4'd1,
        CFG_MASK_COLS    = 4'd2,
        CFG_MIN_HITS     = 4'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REQ_CTRL  = 2'd0,
        REQ_MASK  = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        K_CTRL  = 2'd0,
        K_MASK  = 2'd1,
        K_QUERY = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [COORD_W-1:0]  p1_x;
        logic signed [COORD_W-1:0]  p1_y;
        logic signed [COORD_W-1:0]  p2_x;
        logic signed [COORD_W-1:0]  p2_y;
        logic signed [COORD_W-1:0]  q1_x;
        logic signed [COORD_W-1:0]  q1_y;
        logic signed [COORD_W-1:0]  q2_x;
        logic signed [COORD_W-1:0]  q2_y;
        logic                       swap_second;
        logic [IDX_W-1:0]           entry_index;
        logic [WORD_W-1:0]          load_word;
    } t_in_item;

    typedef struct packed {
        logic [HIT_W-1:0] hit_count;
        logic             passes;
        logic             degenerate;
    } t_out_item;

    typedef struct packed {
        t_kind                      kind;
        logic [IDX_W-1:0]           index;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y1;
        logic signed [COORD_W-1:0]  x3;
        logic signed [COORD_W-1:0]  y3;
        logic signed [DIFF_W-1:0]   d1x;
        logic signed [DIFF_W-1:0]   d1y;
        logic signed [DIFF_W-1:0]   d2x;
        logic signed [DIFF_W-1:0]   d2y;
        logic                       degenerate;
        logic [WORD_W-1:0]          word;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] num_controls;
        logic [CFG_W-1:0] mask_rows_used;
        logic [CFG_W-1:0] mask_cols_used;
        logic [CFG_W-1:0] min_hits;
    } t_cfg;

    localparam int QUEUE_DEPTH = 2;

endpackage

>>> rtl/sms_in_if.sv
// input channel of the similarity mask scoring block
// valid/ready handshake carrying one t_in_item word, depends on sms_pkg
interface sms_in_if import sms_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sms_out_if.sv
// result channel of the similarity mask scoring block
// valid/ready handshake carrying one t_out_item word, depends on sms_pkg
interface sms_out_if import sms_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sms_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module sms_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/sms_front.sv
// front end: accepts input words, drops ignored ones, forms queue commands
// depends on sms_pkg and sms_in_if
module sms_front import sms_pkg::*; #(
    parameter int MAX_CONTROLS = MAX_CONTROLS_DEF,
    parameter int MASK_ROWS    = MASK_ROWS_DEF
) (
    sms_in_if.sink i_in,
    input  logic   i_clearing,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);
    logic keep;
    logic idx_ctrl_ok;
    logic idx_row_ok;

    assign i_in.ready  = !i_q_full && !i_clearing;
    assign idx_ctrl_ok = 32'(i_in.data.entry_index) < MAX_CONTROLS;
    assign idx_row_ok  = 32'(i_in.data.entry_index) < MASK_ROWS;

    always_comb begin
        o_cmd.index = i_in.data.entry_index;
        o_cmd.x1    = i_in.data.p1_x;
        o_cmd.y1    = i_in.data.p1_y;
        o_cmd.word  = i_in.data.load_word;
        if (i_in.data.swap_second) begin
            o_cmd.x3 = i_in.data.q2_x;
            o_cmd.y3 = i_in.data.q2_y;
            o_cmd.d2x = DIFF_W'(i_in.data.q2_x) - DIFF_W'(i_in.data.q1_x);
            o_cmd.d2y = DIFF_W'(i_in.data.q2_y) - DIFF_W'(i_in.data.q1_y);
        end else begin
            o_cmd.x3 = i_in.data.q1_x;
            o_cmd.y3 = i_in.data.q1_y;
            o_cmd.d2x = DIFF_W'(i_in.data.q1_x) - DIFF_W'(i_in.data.q2_x);
            o_cmd.d2y = DIFF_W'(i_in.data.q1_y) - DIFF_W'(i_in.data.q2_y);
        end
        o_cmd.d1x = DIFF_W'(i_in.data.p1_x) - DIFF_W'(i_in.data.p2_x);
        o_cmd.d1y = DIFF_W'(i_in.data.p1_y) - DIFF_W'(i_in.data.p2_y);
        o_cmd.degenerate = (o_cmd.d1x == '0) && (o_cmd.d1y == '0);

        keep       = 1'b0;
        o_cmd.kind = K_QUERY;
        unique case (i_in.data.req_type)
            REQ_CTRL: begin
                o_cmd.kind = K_CTRL;
                keep       = idx_ctrl_ok;
            end
            REQ_MASK: begin
                o_cmd.kind = K_MASK;
                keep       = idx_row_ok;
            end
            REQ_QUERY: begin
                o_cmd.kind = K_QUERY;
                keep       = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_push = i_in.valid && i_in.ready && keep;
endmodule

>>> rtl/sms_queue.sv
// two entry command queue between the front end and the back end
// depends on sms_pkg
module sms_queue import sms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_cmd o_cmd
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule

>>> rtl/sms_div.sv
// restoring divider, one quotient bit per cycle, q16 result saturated
// depends on sms_pkg
module sms_div import sms_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [NUM_W-1:0]    i_den,
    output logic                o_done,
    output logic [AB_MAG_W-1:0] o_mag
);
    localparam int DW = NUM_W + AB_FRAC;
    localparam int KW = $clog2(DW + 1);

    logic [DW-1:0]    r_dvd;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [KW-1:0]    r_cnt;
    logic             r_done;
    logic [NUM_W:0]   rem_sh;
    logic [NUM_W+1:0] diff;
    logic             ge;

    assign rem_sh = {r_rem, r_dvd[DW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_den};
    assign ge     = !diff[NUM_W+1];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_num, {AB_FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
            r_dvd <= {r_dvd[DW-2:0], ge};
        end
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == KW'(1)) && !i_start;
            if (i_start) begin
                r_cnt <= KW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // quotient at or above 2^36 clips to the largest magnitude
    assign o_done = r_done;
    assign o_mag  = (r_dvd[DW-1:AB_MAG_W] != '0) ? {AB_MAG_W{1'b1}} : r_dvd[AB_MAG_W-1:0];
endmodule

>>> rtl/sms_back.sv
// back end: executes loads, fits the transform and scans the control points
// depends on sms_pkg, sms_out_if, sms_ram and sms_div
module sms_back import sms_pkg::*; #(
    parameter int MAX_CONTROLS    = MAX_CONTROLS_DEF,
    parameter int MASK_ROWS       = MASK_ROWS_DEF,
    parameter int MASK_COLS       = MASK_COLS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_q_valid,
    input  t_cmd         i_q_cmd,
    output logic         o_q_pop,
    output logic         o_clearing,
    sms_out_if.source    o_out
);
    localparam int AW  = (MAX_CONTROLS > 1) ? $clog2(MAX_CONTROLS) : 1;
    localparam int MAW = (MASK_ROWS > 1) ? $clog2(MASK_ROWS) : 1;
    localparam int RCW = $clog2(MASK_ROWS + 1);
    localparam int CBW = (MASK_COLS > 1) ? $clog2(MASK_COLS) : 1;
    localparam int CW  = $clog2(MAX_CONTROLS + 1);
    localparam int SH  = AB_FRAC + COORD_FRAC_BITS;
    localparam int LO_W = 18;
    localparam int HI_W = AB_W - LO_W;
    localparam int PP_W = HI_W + DIFF_W;
    localparam int MAP_W = 64;
    localparam int NPIPE = 6;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_CLEAR = 8'b00000010,
        ST_MUL   = 8'b00000100,
        ST_SUM   = 8'b00001000,
        ST_START = 8'b00010000,
        ST_DIV   = 8'b00100000,
        ST_SCAN  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [RCW-1:0] r_clr;
    logic [CW-1:0]  r_k;
    logic [CW-1:0]  r_hits;
    logic           r_degen;
    logic [NPIPE-1:0] r_pv;
    logic           r_out_valid;
    t_out_item      r_out;

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [SUM_W-1:0]  r_num_a, r_num_b, r_den;
    logic signed [AB_W-1:0]   r_a, r_b;

    logic signed [DIFF_W-1:0] r_ex, r_ey;
    logic signed [PP_W-1:0]   r_pah_x, r_pal_x, r_pbh_x, r_pbl_x;
    logic signed [PP_W-1:0]   r_pah_y, r_pal_y, r_pbh_y, r_pbl_y;
    logic signed [MAP_W-1:0]  r_ax, r_ay, r_bx, r_by;
    logic signed [MAP_W-1:0]  r_mx, r_my;
    logic                     r_hitok;
    logic [CBW-1:0]           r_col;

    logic [CW-1:0]        n_ctl;
    logic                 issue;
    logic                 scan_done;
    logic                 out_load;
    logic                 div_done;
    logic [AB_MAG_W-1:0]  mag_a, mag_b;
    logic [NUM_W-1:0]     abs_a, abs_b;
    logic [31:0]          idx32;
    logic [31:0]          k32;
    logic [31:0]          row32;

    logic                 ctrl_we;
    logic [2*COORD_W-1:0] ctrl_rdata;
    logic                 mask_we;
    logic [MAW-1:0]       mask_waddr;
    logic [MASK_COLS-1:0] mask_wdata;
    logic [MAW-1:0]       mask_raddr;
    logic [MASK_COLS-1:0] mask_rdata;

    logic signed [HI_W-1:0] a_hi, a_lo, b_hi, b_lo;
    logic signed [MAP_W-1:0] vx_int, vy_int;
    logic [MAP_W-1:0]        rows64, cols64;
    logic                    x_small, y_small, row_ok, col_ok;

    assign n_ctl = (32'(i_cfg.num_controls) < MAX_CONTROLS) ?
                   CW'(i_cfg.num_controls) : CW'(MAX_CONTROLS);
    assign issue     = (r_state == ST_SCAN) && (r_k != n_ctl);
    assign scan_done = (r_state == ST_SCAN) && (r_k == n_ctl) && (r_pv == '0);
    assign out_load  = (r_state == ST_OUT) && (!r_out_valid || o_out.ready);
    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid;
    assign o_clearing = (r_state == ST_CLEAR);

    assign idx32 = 32'(i_q_cmd.index);
    assign k32   = 32'(r_k);

    // load paths and the clearing sweep
    assign ctrl_we    = o_q_pop && (i_q_cmd.kind == K_CTRL);
    assign mask_we    = (r_state == ST_CLEAR) || (o_q_pop && (i_q_cmd.kind == K_MASK));
    assign mask_waddr = (r_state == ST_CLEAR) ? r_clr[MAW-1:0] : idx32[MAW-1:0];
    assign mask_wdata = (r_state == ST_CLEAR) ? '0 : i_q_cmd.word[MASK_COLS-1:0];

    sms_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_CONTROLS)) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (ctrl_we),
        .i_waddr (idx32[AW-1:0]),
        .i_wdata ({i_q_cmd.x1, i_q_cmd.y1}),
        .i_raddr (k32[AW-1:0]),
        .o_rdata (ctrl_rdata)
    );

    sms_ram #(.WIDTH(MASK_COLS), .DEPTH(MASK_ROWS)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (mask_waddr),
        .i_wdata (mask_wdata),
        .i_raddr (mask_raddr),
        .o_rdata (mask_rdata)
    );

    assign abs_a = r_num_a[SUM_W-1] ? NUM_W'(-r_num_a) : NUM_W'(r_num_a);
    assign abs_b = r_num_b[SUM_W-1] ? NUM_W'(-r_num_b) : NUM_W'(r_num_b);

    sms_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_num   (abs_a),
        .i_den   (NUM_W'(r_den)),
        .o_done  (div_done),
        .o_mag   (mag_a)
    );

    sms_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_START),
        .i_num   (abs_b),
        .i_den   (NUM_W'(r_den)),
        .o_done  (),
        .o_mag   (mag_b)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && (i_q_cmd.kind == K_QUERY)) begin
                    n_state = i_q_cmd.degenerate ? ST_OUT : ST_MUL;
                end
            end
            ST_CLEAR: begin
                if (r_clr == RCW'(MASK_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_START;
            ST_START: n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // split a and b so each partial product stays narrow
    assign a_hi = r_a[AB_W-1:LO_W];
    assign a_lo = $signed({1'b0, r_a[LO_W-1:0]});
    assign b_hi = r_b[AB_W-1:LO_W];
    assign b_lo = $signed({1'b0, r_b[LO_W-1:0]});

    // truncation toward zero: values in (-1,0) land on index 0
    assign vx_int  = r_mx >>> SH;
    assign vy_int  = r_my >>> SH;
    assign x_small = r_mx[MAP_W-1] && (vx_int == -64'sd1) && (r_mx[SH-1:0] != '0);
    assign y_small = r_my[MAP_W-1] && (vy_int == -64'sd1) && (r_my[SH-1:0] != '0);
    assign rows64  = (32'(i_cfg.mask_rows_used) < MASK_ROWS) ?
                     MAP_W'(i_cfg.mask_rows_used) : MAP_W'(MASK_ROWS);
    assign cols64  = (32'(i_cfg.mask_cols_used) < MASK_COLS) ?
                     MAP_W'(i_cfg.mask_cols_used) : MAP_W'(MASK_COLS);
    assign row_ok  = x_small ? (rows64 != '0) :
                     (!r_mx[MAP_W-1] && ($unsigned(vx_int) < rows64));
    assign col_ok  = y_small ? (cols64 != '0) :
                     (!r_my[MAP_W-1] && ($unsigned(vy_int) < cols64));
    assign row32   = x_small ? 32'd0 : 32'(vx_int);
    assign mask_raddr = row32[MAW-1:0];

    always_ff @(posedge i_clk) begin
        // datapath, no reset
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        r_p0 <= r_cmd.d2x * r_cmd.d1x;
        r_p1 <= r_cmd.d2y * r_cmd.d1y;
        r_p2 <= r_cmd.d2y * r_cmd.d1x;
        r_p3 <= r_cmd.d1y * r_cmd.d2x;
        r_p4 <= r_cmd.d1x * r_cmd.d1x;
        r_p5 <= r_cmd.d1y * r_cmd.d1y;
        r_num_a <= SUM_W'(r_p0) + SUM_W'(r_p1);
        r_num_b <= SUM_W'(r_p2) - SUM_W'(r_p3);
        r_den   <= SUM_W'(r_p4) + SUM_W'(r_p5);
        if (r_state == ST_DIV && div_done) begin
            r_a <= r_num_a[SUM_W-1] ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
            r_b <= r_num_b[SUM_W-1] ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
        end

        r_ex <= DIFF_W'($signed(ctrl_rdata[2*COORD_W-1:COORD_W])) - DIFF_W'(r_cmd.x1);
        r_ey <= DIFF_W'($signed(ctrl_rdata[COORD_W-1:0])) - DIFF_W'(r_cmd.y1);

        r_pah_x <= a_hi * r_ex;
        r_pal_x <= a_lo * r_ex;
        r_pbh_x <= b_hi * r_ex;
        r_pbl_x <= b_lo * r_ex;
        r_pah_y <= a_hi * r_ey;
        r_pal_y <= a_lo * r_ey;
        r_pbh_y <= b_hi * r_ey;
        r_pbl_y <= b_lo * r_ey;

        r_ax <= (MAP_W'(r_pah_x) <<< LO_W) + MAP_W'(r_pal_x);
        r_bx <= (MAP_W'(r_pbh_x) <<< LO_W) + MAP_W'(r_pbl_x);
        r_ay <= (MAP_W'(r_pah_y) <<< LO_W) + MAP_W'(r_pal_y);
        r_by <= (MAP_W'(r_pbh_y) <<< LO_W) + MAP_W'(r_pbl_y);

        r_mx <= (MAP_W'(r_cmd.x3) <<< AB_FRAC) + r_ax - r_by;
        r_my <= (MAP_W'(r_cmd.y3) <<< AB_FRAC) + r_bx + r_ay;

        r_hitok <= row_ok && col_ok;
        r_col   <= CBW'(col_ok && !y_small ? vy_int : 64'sd0);

        if (out_load) begin
            r_out.hit_count  <= (32'(r_hits) > 32'd127) ? HIT_W'(127) : HIT_W'(r_hits);
            r_out.passes     <= (32'(r_hits) > 32'(i_cfg.min_hits)) && !r_degen;
            r_out.degenerate <= r_degen;
        end

        // control
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_hits      <= '0;
            r_degen     <= 1'b0;
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (o_q_pop && (i_q_cmd.kind == K_QUERY)) begin
                r_degen <= i_q_cmd.degenerate;
                r_hits  <= '0;
                r_k     <= '0;
            end else if (issue) begin
                r_k <= r_k + 1'b1;
            end
            r_pv <= {r_pv[NPIPE-2:0], issue};
            if (r_pv[NPIPE-1] && r_hitok && mask_rdata[r_col]) begin
                r_hits <= r_hits + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule

>>> rtl/similarity_mask_score.sv
// top level of the similarity mask scoring block
// depends on sms_pkg, sms_in_if, sms_out_if, sms_front, sms_queue, sms_back
//
// Usage: words on i_in either load a control point (req_type 0), load a mask
// row (req_type 1) or run a score query (req_type 2); req_type 3 and loads
// with an index beyond the store are taken and dropped. Only a query gives a
// result word on o_out: hit count, pass flag and the degenerate flag.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must do so only while idle, the block itself does not enforce it. A query
// forms products, then sums, then runs the bit-per-cycle divider that forms
// a and b, then scans the control points through the scan pipeline; a query
// with a coincident first pair skips these steps and goes straight to the
// result. A two-word queue lets new words come in while a query runs.
// After reset the mask rows are swept to zero, one row per cycle, with
// i_in.ready low during the sweep. A result held on o_out waits for
// o_out.ready while the queue keeps taking input until it fills.
module similarity_mask_score import sms_pkg::*; #(
    parameter int MAX_CONTROLS    = MAX_CONTROLS_DEF,
    parameter int MASK_ROWS       = MASK_ROWS_DEF,
    parameter int MASK_COLS       = MASK_COLS_DEF,
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sms_in_if.sink               i_in,
    sms_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd q_cmd;
    logic front_push;
    logic q_valid;
    logic q_full;
    logic q_pop;
    logic clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_controls   <= CFG_W'(1);
            r_cfg.mask_rows_used <= CFG_W'(64);
            r_cfg.mask_cols_used <= CFG_W'(64);
            r_cfg.min_hits       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_CONTROLS: r_cfg.num_controls   <= i_cfg_data;
                CFG_MASK_ROWS:    r_cfg.mask_rows_used <= i_cfg_data;
                CFG_MASK_COLS:    r_cfg.mask_cols_used <= i_cfg_data;
                CFG_MIN_HITS:     r_cfg.min_hits       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sms_front #(.MAX_CONTROLS(MAX_CONTROLS), .MASK_ROWS(MASK_ROWS)) u_front (
        .i_in       (i_in),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (front_push),
        .o_cmd      (front_cmd)
    );

    sms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd)
    );

    sms_back #(
        .MAX_CONTROLS    (MAX_CONTROLS),
        .MASK_ROWS       (MASK_ROWS),
        .MASK_COLS       (MASK_COLS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_out      (o_out)
    );
endmodule

>>> rtl/sms_checker.sv
// port level checks for the similarity mask scoring block, bound to the top
// depends on sms_pkg and similarity_mask_score
module sms_checker import sms_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [HIT_W-1:0] i_hit_count,
    input logic             i_passes,
    input logic             i_degenerate
);
    // mask clearing keeps the input closed right after reset
    a_clear_closed: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input open during mask clearing");

    a_no_out_after_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> (i_hit_count == '0) && !i_passes)
        else $error("degenerate result with hits");

    a_pass_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_passes |-> i_hit_count != '0)
        else $error("pass with zero hits");
endmodule

bind similarity_mask_score sms_checker u_sms_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_hit_count  (o_out.data.hit_count),
    .i_passes     (o_out.data.passes),
    .i_degenerate (o_out.data.degenerate)
);

>>> tb/sv/similarity_mask_score_tb.sv
// self-checking testbench for similarity_mask_score: loads, queries and register phases
// depends on sms_pkg, sms_in_if, sms_out_if and the similarity_mask_score rtl
module similarity_mask_score_tb import sms_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    class sms_score_model;
        localparam longint unsigned AB_LIMIT = (64'd1 << 36) - 1;
        localparam int FRAC_SUM = 16 + 8;

        logic [23:0] ctl_x [64];
        logic [23:0] ctl_y [64];
        bit          ctl_written [64];
        logic [63:0] mask_rows [64];
        logic [6:0]  num_controls = 7'd1;
        logic [6:0]  rows_used    = 7'd64;
        logic [6:0]  cols_used    = 7'd64;
        logic [6:0]  min_hits     = 7'd0;
        t_out_item   score_q [$];
        int          errors = 0;

        function new();
            for (int i = 0; i < 64; i++) begin
                ctl_x[i] = '0;
                ctl_y[i] = '0;
                ctl_written[i] = 0;
                mask_rows[i] = '0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_NUM_CONTROLS: num_controls = val;
                CFG_MASK_ROWS:    rows_used = val;
                CFG_MASK_COLS:    cols_used = val;
                CFG_MIN_HITS:     min_hits = val;
                default: ;
            endcase
        endfunction

        // first control entry not yet loaded, 64 when all are
        function int first_unloaded();
            for (int i = 0; i < 64; i++)
                if (!ctl_written[i]) return i;
            return 64;
        endfunction

        function bit controls_loaded();
            int n;
            n = (num_controls < 64) ? num_controls : 64;
            return first_unloaded() >= n;
        endfunction

        // signed quotient in Q16, truncated toward zero, magnitude saturated
        function longint div_q16(longint num, longint den);
            bit neg;
            longint unsigned un, ud, q, r, mag;
            neg = num < 0;
            un = neg ? -num : num;
            ud = den;
            q = un / ud;
            r = un % ud;
            if (q >= (64'd1 << 20)) begin
                mag = AB_LIMIT;
            end else begin
                mag = q;
                for (int k = 0; k < 16; k++) begin
                    r = r << 1;
                    mag = mag << 1;
                    if (r >= ud) begin
                        r = r - ud;
                        mag = mag | 1;
                    end
                end
                if (mag > AB_LIMIT) mag = AB_LIMIT;
            end
            return neg ? -longint'(mag) : longint'(mag);
        endfunction

        // truncation toward zero, fails on a negative integer part
        function bit cell_of(longint v, output longint unsigned idx);
            longint unsigned m;
            idx = 0;
            if (v < 0) begin
                m = -v;
                return (m >> FRAC_SUM) == 0;
            end
            idx = longint'(v) >>> FRAC_SUM;
            return 1;
        endfunction

        function void note_word(t_in_item w);
            longint x1, y1, x2, y2, x3, y3, x4, y4, d1x, d1y, d2x, d2y, den, a, b;
            longint ex, ey, mx, my;
            longint unsigned r, c, nrow, ncol, n, hits;
            t_out_item res;
            case (w.req_type)
                REQ_CTRL: begin
                    ctl_x[w.entry_index] = w.p1_x;
                    ctl_y[w.entry_index] = w.p1_y;
                    ctl_written[w.entry_index] = 1;
                end
                REQ_MASK: mask_rows[w.entry_index] = w.load_word;
                REQ_QUERY: begin
                    x1 = $signed(w.p1_x); y1 = $signed(w.p1_y);
                    x2 = $signed(w.p2_x); y2 = $signed(w.p2_y);
                    if (w.swap_second) begin
                        x3 = $signed(w.q2_x); y3 = $signed(w.q2_y);
                        x4 = $signed(w.q1_x); y4 = $signed(w.q1_y);
                    end else begin
                        x3 = $signed(w.q1_x); y3 = $signed(w.q1_y);
                        x4 = $signed(w.q2_x); y4 = $signed(w.q2_y);
                    end
                    d1x = x1 - x2; d1y = y1 - y2;
                    d2x = x3 - x4; d2y = y3 - y4;
                    res = '0;
                    if (d1x == 0 && d1y == 0) begin
                        res.degenerate = 1'b1;
                    end else begin
                        den = d1x * d1x + d1y * d1y;
                        a = div_q16(d2x * d1x + d2y * d1y, den);
                        b = div_q16(d2y * d1x - d1y * d2x, den);
                        nrow = (rows_used < 64) ? rows_used : 64;
                        ncol = (cols_used < 64) ? cols_used : 64;
                        n = (num_controls < 64) ? num_controls : 64;
                        hits = 0;
                        for (int k = 0; k < n; k++) begin
                            ex = longint'($signed(ctl_x[k])) - x1;
                            ey = longint'($signed(ctl_y[k])) - y1;
                            mx = x3 * 65536 + a * ex - b * ey;
                            my = y3 * 65536 + b * ex + a * ey;
                            if (cell_of(mx, r) && cell_of(my, c))
                                if (r < nrow && c < ncol && mask_rows[r][c]) hits++;
                        end
                        res.hit_count = (hits > 127) ? 7'd127 : hits[6:0];
                        res.passes = hits > min_hits;
                    end
                    score_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (score_q.size() == 0) begin
                $error("result word with no query pending: hit_count %0d", got.hit_count);
                errors++;
                return;
            end
            want = score_q.pop_front();
            if (got.hit_count !== want.hit_count) begin
                $error("hit_count expected %0d actual %0d", want.hit_count, got.hit_count);
                errors++;
            end
            if (got.passes !== want.passes) begin
                $error("passes expected %0d actual %0d", want.passes, got.passes);
                errors++;
            end
            if (got.degenerate !== want.degenerate) begin
                $error("degenerate expected %0d actual %0d", want.degenerate, got.degenerate);
                errors++;
            end
        endfunction
    endclass

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 4'd12;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_WORDS = 250;
    localparam int NUM_PHASES = 7;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    sms_in_if  in_ch ();
    sms_out_if out_ch ();

    similarity_mask_score dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    sms_score_model sb = new();
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall, long hold-off on request
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

    task automatic send_word(t_in_item w);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(w);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (sb.score_q.size() != 0) @(posedge i_clk);
        // a trailing load or dropped word may still be in flight
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick(int lo, int hi);
        return 24'(int'($urandom_range(0, hi - lo)) + lo);
    endfunction

    function automatic t_in_item noise_word();
        t_in_item w;
        w = $bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom});
        return w;
    endfunction

    function automatic t_in_item ctl_word(int idx);
        t_in_item w;
        w = noise_word();
        w.req_type = REQ_CTRL;
        w.entry_index = IDX_W'(idx);
        if ($urandom_range(0, 9) == 0) return w;
        w.p1_x = pick(-512, 64 * 256 + 512);
        w.p1_y = pick(-512, 64 * 256 + 512);
        return w;
    endfunction

    function automatic t_in_item mask_word();
        t_in_item w;
        w = noise_word();
        w.req_type = REQ_MASK;
        case ($urandom_range(0, 3))
            0: w.load_word = '1;
            1: w.load_word = w.load_word | {$urandom, $urandom};
            default: ;
        endcase
        return w;
    endfunction

    // well-formed query for shapes 0 to 2: identity, quarter turn or double scale, shifted
    function automatic t_in_item query_word(int shape);
        t_in_item w;
        int x1, y1, dx, dy, tx, ty, fx, fy, sx, sy;
        w = noise_word();
        w.req_type = REQ_QUERY;
        if (shape == 4) return w;
        x1 = int'($urandom_range(0, 17000)) - 512;
        y1 = int'($urandom_range(0, 17000)) - 512;
        dx = int'($urandom_range(1, 2000)) * ($urandom_range(0, 1) ? 1 : -1);
        dy = int'($urandom_range(0, 4000)) - 2000;
        if (shape == 3) begin
            dx = 0;
            dy = 0;
        end
        tx = int'($urandom_range(0, 2048)) - 1024;
        ty = int'($urandom_range(0, 2048)) - 1024;
        fx = x1 + tx;
        fy = y1 + ty;
        case (shape)
            1: begin sx = fx + dy; sy = fy - dx; end
            2: begin sx = fx - 2 * dx; sy = fy - 2 * dy; end
            default: begin sx = fx - dx; sy = fy - dy; end
        endcase
        w.p1_x = 24'(x1); w.p1_y = 24'(y1);
        w.p2_x = 24'(x1 - dx); w.p2_y = 24'(y1 - dy);
        if (w.swap_second) begin
            w.q2_x = 24'(fx); w.q2_y = 24'(fy); w.q1_x = 24'(sx); w.q1_y = 24'(sy);
        end else begin
            w.q1_x = 24'(fx); w.q1_y = 24'(fy); w.q2_x = 24'(sx); w.q2_y = 24'(sy);
        end
        return w;
    endfunction

    function automatic t_in_item random_word();
        t_in_item w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return ctl_word($urandom_range(0, 63));
        if (r < 35) return mask_word();
        if (r < 42) w = noise_word();
        else w = query_word($urandom_range(0, 9) < 8 ? $urandom_range(0, 2)
                                                      : $urandom_range(3, 4));
        // never score against a control entry that was never loaded
        if (w.req_type == REQ_QUERY && !sb.controls_loaded())
            w = ctl_word(sb.first_unloaded());
        return w;
    endfunction

    task automatic directed_words();
        t_in_item w;
        w = '0; w.req_type = REQ_MASK; w.entry_index = 0; w.load_word = '1;
        send_word(w);
        w.entry_index = 63; w.load_word = 64'h8000_0000_0000_0001;
        send_word(w);
        // control just below zero truncates into cell zero
        w = '0; w.req_type = REQ_CTRL; w.p1_x = -24'sd128; w.p1_y = -24'sd128;
        send_word(w);
        w = '0; w.req_type = REQ_QUERY; w.p2_x = 24'sd256; w.q2_x = 24'sd256;
        send_word(w);
        w.swap_second = 1'b1; w.q2_x = 24'sd0; w.q1_x = 24'sd256;
        send_word(w);
        // coincident first pair at the field extremes
        w = '1; w.req_type = REQ_QUERY;
        w.p1_x = 24'h7FFFFF; w.p2_x = 24'h7FFFFF; w.p1_y = 24'h800000; w.p2_y = 24'h800000;
        send_word(w);
        w = '1;
        send_word(w);
        w = '0; w.req_type = REQ_QUERY;
        w.p1_x = 24'h800000; w.p2_x = 24'h7FFFFF; w.p1_y = 24'h7FFFFF; w.p2_y = 24'h800000;
        w.q1_x = 24'h7FFFFF; w.q2_x = 24'h800000; w.q1_y = 24'h800000; w.q2_y = 24'h7FFFFF;
        send_word(w);
        // unit first pair against a huge second pair saturates a and b
        w = '0; w.req_type = REQ_QUERY; w.p1_x = 24'sd1;
        w.q1_x = 24'h7FFFFF; w.q2_x = 24'h800000; w.q1_y = 24'h800000; w.q2_y = 24'h7FFFFF;
        send_word(w);
        w = '0; w.req_type = REQ_CTRL; w.entry_index = 63;
        w.p1_x = 24'h7FFFFF; w.p1_y = 24'h800000;
        send_word(w);
        w = '0; w.req_type = REQ_MASK; w.entry_index = 5; w.load_word = '1;
        send_word(w);
        w = '0; w.req_type = REQ_CTRL; w.p1_x = 24'sd1280 + 24'sd64; w.p1_y = 24'sd1280;
        send_word(w);
        w = '0; w.req_type = REQ_QUERY; w.p2_x = 24'sd256; w.q2_x = 24'sd256;
        send_word(w);
    endtask

    logic [CFG_W-1:0] cfg_tab [NUM_PHASES][4] = '{
        '{7'd1, 7'd64, 7'd64, 7'd0},
        '{7'd64, 7'd64, 7'd64, 7'd0},
        '{7'd127, 7'd127, 7'd127, 7'd127},
        '{7'd37, 7'd20, 7'd50, 7'd10},
        '{7'd0, 7'd1, 7'd1, 7'd64},
        '{7'd64, 7'd64, 7'd64, 7'd3},
        '{7'd12, 7'd0, 7'd0, 7'd1}
    };

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_words();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            write_reg(CFG_NUM_CONTROLS, cfg_tab[ph][0]);
            write_reg(CFG_MASK_ROWS, cfg_tab[ph][1]);
            write_reg(CFG_MASK_COLS, cfg_tab[ph][2]);
            write_reg(CFG_MIN_HITS, cfg_tab[ph][3]);
            write_reg(CFG_IDX_UNUSED, 7'h7F);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 75; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 75; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            // back up the result side so the input queue fills and stalls
            if (ph == 1) hold_cycles = 3000;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (ph == 3 && i == PHASE_WORDS / 2) begin
                    idle_cycles(1);
                    while (sb.score_q.size() != 0) @(posedge i_clk);
                end
                send_word(random_word());
                if ((i / 40) % 2 == 0 && $urandom_range(0, 99) < send_idle_pct)
                    idle_cycles($urandom_range(1, 6));
            end
        end
        drain();

        if (sb.errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
